FILE: design/pdpm_pkg.sv
// Shared types and constants for the peer discovery poll master.
// No dependencies; imported by the controller, the datapath and the register block.
`default_nettype none
package pdpm_pkg;

	// item mode codes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_DISC = 2'd1;
	localparam logic [1:0] MODE_POLL = 2'd2;

	// register reset values
	localparam logic [15:0] RST_DISCOVER_INTERVAL = 16'd10000;
	localparam logic [15:0] RST_DISCOVER_WINDOW   = 16'd2000;
	localparam logic [15:0] RST_POLL_INTERVAL     = 16'd1000;
	localparam logic [15:0] RST_POLL_TIMEOUT      = 16'd200;
	localparam logic [15:0] RST_STALE_LIMIT       = 16'd60000;
	localparam logic [15:0] RST_PUBLISH_INTERVAL  = 16'd2000;

	// configuration registers
	typedef struct packed {
		logic [15:0] discover_interval;
		logic [15:0] discover_window;
		logic [15:0] poll_interval;
		logic [15:0] poll_timeout;
		logic [15:0] stale_limit;
		logic [15:0] publish_interval;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch item, clear index, advance time on a tick
		logic idx_inc;    // next table entry
		logic idx_cursor; // index from poll cursor
		logic stale_chk;  // stale test of entry at index
		logic seq;        // one sequencer step
		logic resp;       // apply a response at index
		logic nop;        // empty result for an unused mode
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic idx_lt_fill;  // index points at a filled entry
		logic act_at_idx;   // entry at index is active
		logic mac_match;    // read MAC equals item MAC
		logic need_search;  // sequencer is picking the next peer
		logic need_mac;     // sequencer is about to send a poll
	} stat_t;

endpackage
`default_nettype wire

FILE: design/pdpm_cfg.sv
// APB register block holding the six timing registers.
// Depends on pdpm_pkg.
`default_nettype none
module pdpm_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output pdpm_pkg::cfg_t    cfg
);
	import pdpm_pkg::*;

	localparam logic [2:0] REG_DISC_INT = 3'd0;
	localparam logic [2:0] REG_DISC_WIN = 3'd1;
	localparam logic [2:0] REG_POLL_INT = 3'd2;
	localparam logic [2:0] REG_POLL_TO  = 3'd3;
	localparam logic [2:0] REG_STALE    = 3'd4;
	localparam logic [2:0] REG_PUB_INT  = 3'd5;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.discover_interval <= RST_DISCOVER_INTERVAL;
			cfg_q.discover_window   <= RST_DISCOVER_WINDOW;
			cfg_q.poll_interval     <= RST_POLL_INTERVAL;
			cfg_q.poll_timeout      <= RST_POLL_TIMEOUT;
			cfg_q.stale_limit       <= RST_STALE_LIMIT;
			cfg_q.publish_interval  <= RST_PUBLISH_INTERVAL;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DISC_INT: cfg_q.discover_interval <= pwdata[15:0];
				REG_DISC_WIN: cfg_q.discover_window   <= pwdata[15:0];
				REG_POLL_INT: cfg_q.poll_interval     <= pwdata[15:0];
				REG_POLL_TO:  cfg_q.poll_timeout      <= pwdata[15:0];
				REG_STALE:    cfg_q.stale_limit       <= pwdata[15:0];
				REG_PUB_INT:  cfg_q.publish_interval  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_DISC_INT: prdata = {16'd0, cfg_q.discover_interval};
			REG_DISC_WIN: prdata = {16'd0, cfg_q.discover_window};
			REG_POLL_INT: prdata = {16'd0, cfg_q.poll_interval};
			REG_POLL_TO:  prdata = {16'd0, cfg_q.poll_timeout};
			REG_STALE:    prdata = {16'd0, cfg_q.stale_limit};
			REG_PUB_INT:  prdata = {16'd0, cfg_q.publish_interval};
			default:      prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/pdpm_ctrl.sv
// Controller state machine: walks the peer table one entry at a time
// and tells the datapath when to test, step or update. Depends on pdpm_pkg.
`default_nettype none
module pdpm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     mode,
	input  pdpm_pkg::stat_t     stat,
	output logic                busy,
	output logic                done,
	output pdpm_pkg::cmd_t      cmd
);
	import pdpm_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_T_RD  = 4'd1;
	localparam logic [3:0] ST_T_CHK = 4'd2;
	localparam logic [3:0] ST_STEP  = 4'd3;
	localparam logic [3:0] ST_N_SCAN = 4'd4;
	localparam logic [3:0] ST_M_RD  = 4'd5;
	localparam logic [3:0] ST_M_CHK = 4'd6;
	localparam logic [3:0] ST_L_RD  = 4'd7;
	localparam logic [3:0] ST_L_CHK = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_EMIT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (mode == MODE_TICK) begin
						state_d = ST_T_RD;
					end else if (mode == MODE_DISC || mode == MODE_POLL) begin
						state_d = ST_L_RD;
					end else begin
						cmd.nop = 1'b1;
						state_d = ST_EMIT;
					end
				end
			end
			// stale sweep: memory read settles, then test
			ST_T_RD: begin
				state_d = stat.idx_lt_fill ? ST_T_CHK : ST_STEP;
			end
			ST_T_CHK: begin
				cmd.stale_chk = 1'b1;
				cmd.idx_inc   = 1'b1;
				state_d       = ST_T_RD;
			end
			ST_STEP: begin
				if (stat.need_search) begin
					cmd.idx_cursor = 1'b1;
					state_d        = ST_N_SCAN;
				end else if (stat.need_mac) begin
					cmd.idx_cursor = 1'b1;
					state_d        = ST_M_RD;
				end else begin
					cmd.seq = 1'b1;
					state_d = ST_EMIT;
				end
			end
			// search for the next active peer
			ST_N_SCAN: begin
				if (stat.idx_lt_fill && !stat.act_at_idx) begin
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.seq = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_M_RD: begin
				state_d = ST_M_CHK;
			end
			ST_M_CHK: begin
				cmd.seq = 1'b1;
				state_d = ST_EMIT;
			end
			// MAC lookup
			ST_L_RD: begin
				if (stat.idx_lt_fill) begin
					state_d = ST_L_CHK;
				end else begin
					cmd.resp = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_L_CHK: begin
				if (stat.mac_match) begin
					cmd.resp = 1'b1;
					state_d  = ST_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_L_RD;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

FILE: design/pdpm_dp.sv
// Datapath: peer table memories, active flags, clock and stamps, sequencer
// phase and the result registers. Depends on pdpm_pkg.
`default_nettype none
module pdpm_dp #(
	parameter int PEER_SLOTS = 16,
	localparam int IW = $clog2(PEER_SLOTS + 1),
	localparam int AW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  pdpm_pkg::cfg_t      cfg,
	input  pdpm_pkg::cmd_t      cmd,
	input  wire logic [1:0]     mode,
	input  wire logic [47:0]    src_mac,
	input  wire logic [7:0]     node_id,
	output pdpm_pkg::stat_t     stat,
	output logic [1:0]          action,
	output logic [IW-1:0]       peer_index,
	output logic [47:0]         peer_mac,
	output logic                table_full,
	output logic [IW-1:0]       active_count,
	output logic [IW-1:0]       entry_count
);
	import pdpm_pkg::*;

	localparam logic [2:0] PH_DISCOVER = 3'd0;
	localparam logic [2:0] PH_DWAIT    = 3'd1;
	localparam logic [2:0] PH_PNEXT    = 3'd2;
	localparam logic [2:0] PH_PSEND    = 3'd3;
	localparam logic [2:0] PH_PWAIT    = 3'd4;
	localparam logic [2:0] PH_IDLE     = 3'd5;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_DISC    = 2'd1;
	localparam logic [1:0] ACT_POLL    = 2'd2;
	localparam logic [1:0] ACT_PUBLISH = 2'd3;

	localparam logic [IW-1:0] NONE_IDX = IW'(PEER_SLOTS);
	localparam logic [IW-1:0] ONE_IDX  = IW'(1);

	// table memories
	logic [47:0] mac_mem  [PEER_SLOTS];
	logic [7:0]  node_mem [PEER_SLOTS];
	logic [31:0] seen_mem [PEER_SLOTS];
	logic [47:0] rd_mac_q;
	logic [31:0] rd_seen_q;

	logic [PEER_SLOTS-1:0] act_q;
	logic [IW-1:0] act_cnt_q, filled_q, idx_q, cursor_q;
	logic [2:0]  phase_q;
	logic [31:0] now_q, ph_stamp_q, disc_stamp_q, cyc_stamp_q, pub_stamp_q;
	logic [1:0]  mode_q;
	logic [47:0] mac_q;
	logic [7:0]  node_q;
	logic [1:0]  action_q;
	logic [IW-1:0] pidx_q;
	logic [47:0] pmac_q;
	logic        full_q;

	logic [AW-1:0] addr;
	logic found, stale_hit, exp_dwin, exp_ptmo, exp_dint, exp_pint, exp_pub, resp_full;

	assign addr = idx_q[AW-1:0];

	assign stat.idx_lt_fill = (idx_q < filled_q);
	assign stat.act_at_idx  = act_q[addr];
	assign stat.mac_match   = (rd_mac_q == mac_q);
	assign stat.need_search = (phase_q == PH_PNEXT);
	assign stat.need_mac    = (phase_q == PH_PSEND);

	assign found     = stat.idx_lt_fill & stat.act_at_idx;
	assign stale_hit = act_q[addr] & ((now_q - rd_seen_q) > {16'd0, cfg.stale_limit});
	assign resp_full = !stat.idx_lt_fill && (filled_q >= NONE_IDX);

	// timer expiry tests
	assign exp_dwin = (now_q - ph_stamp_q)   >= {16'd0, cfg.discover_window};
	assign exp_ptmo = (now_q - ph_stamp_q)   >= {16'd0, cfg.poll_timeout};
	assign exp_dint = (now_q - disc_stamp_q) >= {16'd0, cfg.discover_interval};
	assign exp_pint = (now_q - cyc_stamp_q)  >= {16'd0, cfg.poll_interval};
	assign exp_pub  = (now_q - pub_stamp_q)  >= {16'd0, cfg.publish_interval};

	assign action       = action_q;
	assign peer_index   = pidx_q;
	assign peer_mac     = pmac_q;
	assign table_full   = full_q;
	assign active_count = act_cnt_q;
	assign entry_count  = filled_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		rd_mac_q  <= mac_mem[addr];
		rd_seen_q <= seen_mem[addr];
		if (cmd.resp && !resp_full) begin
			mac_mem[addr]  <= mac_q;
			seen_mem[addr] <= now_q;
			if (mode_q == MODE_DISC || !stat.idx_lt_fill) begin
				node_mem[addr] <= node_q;
			end
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			mac_q  <= src_mac;
			node_q <= node_id;
		end
	end

	// control state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= '0;
			act_cnt_q    <= '0;
			filled_q     <= '0;
			idx_q        <= '0;
			cursor_q     <= '0;
			phase_q      <= PH_DISCOVER;
			now_q        <= '0;
			ph_stamp_q   <= '0;
			disc_stamp_q <= '0;
			cyc_stamp_q  <= '0;
			pub_stamp_q  <= '0;
			action_q     <= ACT_NONE;
			pidx_q       <= NONE_IDX;
			pmac_q       <= '0;
			full_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				if (mode == MODE_TICK) begin
					now_q <= now_q + 32'd1;
				end
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + ONE_IDX;
			end
			if (cmd.idx_cursor) begin
				idx_q <= cursor_q;
			end
			if (cmd.nop) begin
				action_q <= ACT_NONE;
				pidx_q   <= NONE_IDX;
				pmac_q   <= '0;
				full_q   <= 1'b0;
			end
			// stale test of one entry
			if (cmd.stale_chk && stale_hit) begin
				act_q[addr] <= 1'b0;
				act_cnt_q   <= act_cnt_q - ONE_IDX;
			end
			// response: update found entry or append, or flag a full table
			if (cmd.resp) begin
				action_q <= ACT_NONE;
				pmac_q   <= '0;
				full_q   <= resp_full;
				pidx_q   <= resp_full ? NONE_IDX : idx_q;
				if (!resp_full) begin
					act_q[addr] <= 1'b1;
					if (!stat.idx_lt_fill) begin
						filled_q  <= filled_q + ONE_IDX;
						act_cnt_q <= act_cnt_q + ONE_IDX;
					end else if (!act_q[addr]) begin
						act_cnt_q <= act_cnt_q + ONE_IDX;
					end
				end
			end
			// sequencer step
			if (cmd.seq) begin
				action_q <= ACT_NONE;
				pidx_q   <= NONE_IDX;
				pmac_q   <= '0;
				full_q   <= 1'b0;
				case (phase_q)
					PH_DISCOVER: begin
						action_q     <= ACT_DISC;
						ph_stamp_q   <= now_q;
						disc_stamp_q <= now_q;
						phase_q      <= PH_DWAIT;
					end
					PH_DWAIT: begin
						if (exp_dwin) begin
							action_q    <= ACT_PUBLISH;
							pub_stamp_q <= now_q;
							cyc_stamp_q <= now_q;
							cursor_q    <= '0;
							phase_q     <= PH_IDLE;
						end
					end
					PH_PNEXT: begin
						if (found) begin
							cursor_q <= idx_q;
							phase_q  <= PH_PSEND;
						end else begin
							action_q    <= ACT_PUBLISH;
							pub_stamp_q <= now_q;
							phase_q     <= PH_IDLE;
						end
					end
					PH_PSEND: begin
						if (cursor_q < NONE_IDX) begin
							action_q <= ACT_POLL;
							pidx_q   <= cursor_q;
							pmac_q   <= rd_mac_q;
						end
						ph_stamp_q <= now_q;
						phase_q    <= PH_PWAIT;
					end
					PH_PWAIT: begin
						if (exp_ptmo) begin
							if (cursor_q < NONE_IDX) begin
								cursor_q <= cursor_q + ONE_IDX;
							end
							phase_q <= PH_PNEXT;
						end
					end
					PH_IDLE: begin
						if (exp_dint) begin
							phase_q <= PH_DISCOVER;
						end else if (exp_pint) begin
							cyc_stamp_q <= now_q;
							cursor_q    <= '0;
							phase_q     <= PH_PNEXT;
						end else if (exp_pub) begin
							action_q    <= ACT_PUBLISH;
							pub_stamp_q <= now_q;
						end
					end
					default: begin
						phase_q <= PH_DISCOVER;
					end
				endcase
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/peer_discovery_poll_master_top.sv
// Top level of the peer discovery poll master: register block, controller
// and datapath. Depends on pdpm_pkg, pdpm_cfg, pdpm_ctrl and pdpm_dp.
//
// Usage:
//   An item (mode, src_mac, node_id) is taken when start is high and busy
//   is low. Mode 0 is a millisecond tick, 1 a discovery response, 2 a poll
//   response. Exactly one result per item appears on the result ports for
//   one cycle, marked by done; the receiver cannot stall it.
//   The peer table sits in single-port memories with registered reads and
//   is walked one entry at a time. A tick runs the stale sweep and a
//   sequencer step, plus where needed a search for the next peer or a
//   read of the MAC to poll; a response walks the table for a matching
//   MAC, else appends or reports a full table. Busy stays high until done.
//   The user writes the timing registers over the APB port only while
//   busy is low; the block itself does not enforce it.
//   Reset clears the table fill count, active flags, time and stamps and
//   puts the sequencer in its discovery phase; registers take defaults.
`default_nettype none
module peer_discovery_poll_master_top #(
	parameter int PEER_SLOTS = 16,
	localparam int IW = $clog2(PEER_SLOTS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [1:0]    mode,
	input  wire logic [47:0]   src_mac,
	input  wire logic [7:0]    node_id,
	output logic               done,
	output logic [1:0]         action,
	output logic [IW-1:0]      peer_index,
	output logic [47:0]        peer_mac,
	output logic               table_full,
	output logic [IW-1:0]      active_count,
	output logic [IW-1:0]      entry_count
);
	import pdpm_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	pdpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	pdpm_dp #(.PEER_SLOTS(PEER_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.mode         (mode),
		.src_mac      (src_mac),
		.node_id      (node_id),
		.stat         (stat),
		.action       (action),
		.peer_index   (peer_index),
		.peer_mac     (peer_mac),
		.table_full   (table_full),
		.active_count (active_count),
		.entry_count  (entry_count)
	);
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for peer_discovery_poll_master_top: ticks and peer responses
// go through a queued driver, and results are checked against an in-bench predictor.
// Depends on pdpm_pkg and the design sources.
`timescale 1ns / 100ps
module tb;
	import pdpm_pkg::*;

	localparam int SLOTS = 16;
	localparam int IW = $clog2(SLOTS + 1);
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_DISCOVER = 2'd1;
	localparam logic [1:0] ACT_POLL = 2'd2;
	localparam logic [1:0] ACT_PUBLISH = 2'd3;
	localparam int REG_DISC_INTERVAL = 0;
	localparam int REG_DISC_WINDOW = 1;
	localparam int REG_POLL_INTERVAL = 2;
	localparam int REG_POLL_TIMEOUT = 3;
	localparam int REG_STALE_LIMIT = 4;
	localparam int REG_PUBLISH_INTERVAL = 5;
	localparam int REG_UNUSED = 6;
	localparam int SETTLE_CYCLES = 60;

	typedef enum logic [2:0] {
		SQ_DISCOVER, SQ_DWAIT, SQ_PNEXT, SQ_PSEND, SQ_PWAIT, SQ_IDLE
	} seq_t;

	typedef enum logic [1:0] {K_ITEM, K_CFG} kind_t;

	typedef struct {
		kind_t       kind;
		logic [1:0]  mode;
		logic [47:0] mac;
		logic [7:0]  node;
		logic [4:0]  addr;
		logic [31:0] data;
		bit          steady;  // no random gap before this item
	} step_t;

	typedef struct {
		logic [1:0]    action;
		logic [IW-1:0] idx;
		logic [47:0]   mac;
		logic          full;
		logic [IW-1:0] acnt;
		logic [IW-1:0] ecnt;
	} result_t;

	// DUT connections, all driven from time zero
	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic [1:0] mode = '0;
	logic [47:0] src_mac = '0;
	logic [7:0] node_id = '0;
	logic done;
	logic [1:0] action;
	logic [IW-1:0] peer_index, active_count, entry_count;
	logic [47:0] peer_mac;
	logic table_full;

	peer_discovery_poll_master_top #(.PEER_SLOTS(SLOTS)) uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] r_disc_int = RST_DISCOVER_INTERVAL, r_disc_win = RST_DISCOVER_WINDOW;
	logic [15:0] r_poll_int = RST_POLL_INTERVAL, r_poll_to = RST_POLL_TIMEOUT;
	logic [15:0] r_stale = RST_STALE_LIMIT, r_pub_int = RST_PUBLISH_INTERVAL;
	logic [47:0] peer_macs [SLOTS];
	logic [7:0]  peer_nodes [SLOTS];
	bit          peer_live [SLOTS];
	logic [31:0] peer_seen [SLOTS];
	int          fill_cnt = 0;
	seq_t        seq_ph = SQ_DISCOVER;
	int          cursor = 0;
	logic [31:0] now_ms = 0, ph_stamp = 0, disc_stamp = 0, cyc_stamp = 0, pub_stamp = 0;

	step_t   pending_items[$];
	result_t due_results[$];
	int      errors = 0;
	bit      took = 0;
	int      apb_st = 0;
	int      settle = 0;
	logic [47:0] mac_pool [20];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			peer_macs[i] = '0; peer_nodes[i] = '0; peer_live[i] = 0; peer_seen[i] = '0;
		end
	end

	function automatic bit expired(logic [31:0] stamp, logic [15:0] span);
		return 32'(now_ms - stamp) >= {16'd0, span};
	endfunction

	// one item through the poll master
	task automatic poll_master_step(input logic [1:0] m, input logic [47:0] mac,
			input logic [7:0] node, output result_t r);
		int slot;
		r = '{action: ACT_NONE, idx: IW'(SLOTS), mac: '0, full: 0, acnt: '0, ecnt: '0};
		if (m == MODE_TICK) begin
			now_ms = now_ms + 1;
			for (int i = 0; i < fill_cnt; i++)
				if (peer_live[i] && 32'(now_ms - peer_seen[i]) > {16'd0, r_stale})
					peer_live[i] = 0;
			case (seq_ph)
				SQ_DISCOVER: begin
					r.action = ACT_DISCOVER;
					ph_stamp = now_ms;
					disc_stamp = now_ms;
					seq_ph = SQ_DWAIT;
				end
				SQ_DWAIT: if (expired(ph_stamp, r_disc_win)) begin
					r.action = ACT_PUBLISH;
					pub_stamp = now_ms;
					cyc_stamp = now_ms;
					cursor = 0;
					seq_ph = SQ_IDLE;
				end
				SQ_PNEXT: begin
					slot = SLOTS;
					for (int i = cursor; i < fill_cnt; i++)
						if (peer_live[i] && slot == SLOTS) slot = i;
					if (slot >= SLOTS) begin
						r.action = ACT_PUBLISH;
						pub_stamp = now_ms;
						seq_ph = SQ_IDLE;
					end else begin
						cursor = slot;
						seq_ph = SQ_PSEND;
					end
				end
				SQ_PSEND: begin
					if (cursor < SLOTS) begin
						r.action = ACT_POLL;
						r.idx = IW'(cursor);
						r.mac = peer_macs[cursor];
					end
					ph_stamp = now_ms;
					seq_ph = SQ_PWAIT;
				end
				SQ_PWAIT: if (expired(ph_stamp, r_poll_to)) begin
					if (cursor < SLOTS) cursor++;
					seq_ph = SQ_PNEXT;
				end
				SQ_IDLE: begin
					if (expired(disc_stamp, r_disc_int)) begin
						seq_ph = SQ_DISCOVER;
					end else if (expired(cyc_stamp, r_poll_int)) begin
						cyc_stamp = now_ms;
						cursor = 0;
						seq_ph = SQ_PNEXT;
					end else if (expired(pub_stamp, r_pub_int)) begin
						r.action = ACT_PUBLISH;
						pub_stamp = now_ms;
					end
				end
				default: seq_ph = SQ_DISCOVER;
			endcase
		end else if (m == MODE_DISC || m == MODE_POLL) begin
			slot = SLOTS;
			for (int i = 0; i < fill_cnt; i++)
				if (peer_macs[i] == mac && slot == SLOTS) slot = i;
			if (slot < SLOTS) begin
				if (m == MODE_DISC) peer_nodes[slot] = node;
				peer_live[slot] = 1;
				peer_seen[slot] = now_ms;
				r.idx = IW'(slot);
			end else if (fill_cnt >= SLOTS) begin
				r.full = 1;
			end else begin
				peer_macs[fill_cnt] = mac;
				peer_nodes[fill_cnt] = node;
				peer_live[fill_cnt] = 1;
				peer_seen[fill_cnt] = now_ms;
				r.idx = IW'(fill_cnt);
				fill_cnt++;
			end
		end
		for (int i = 0; i < fill_cnt; i++)
			if (peer_live[i]) r.acnt++;
		r.ecnt = IW'(fill_cnt);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// monitor: acceptance, register writes and result checks
	always @(posedge clk) begin
		result_t r;
		logic [15:0] v;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", action, 0);
				end else begin
					r = due_results.pop_front();
					if (action !== r.action) report_mismatch("action", action, r.action);
					if (peer_index !== r.idx) report_mismatch("peer_index", peer_index, r.idx);
					if (peer_mac !== r.mac) report_mismatch("peer_mac", peer_mac, r.mac);
					if (table_full !== r.full) report_mismatch("table_full", table_full, r.full);
					if (active_count !== r.acnt)
						report_mismatch("active_count", active_count, r.acnt);
					if (entry_count !== r.ecnt)
						report_mismatch("entry_count", entry_count, r.ecnt);
				end
			end
			if (start && !busy) begin
				poll_master_step(mode, src_mac, node_id, r);
				due_results.push_back(r);
			end
			if (psel && penable && pwrite && pready) begin
				v = pwdata[15:0];
				case (int'(paddr) / 4)
					REG_DISC_INTERVAL: r_disc_int = v;
					REG_DISC_WINDOW: r_disc_win = v;
					REG_POLL_INTERVAL: r_poll_int = v;
					REG_POLL_TIMEOUT: r_poll_to = v;
					REG_STALE_LIMIT: r_stale = v;
					REG_PUBLISH_INTERVAL: r_pub_int = v;
					default: ;
				endcase
			end
		end
	end

	// driver: items with random gaps unless steady, register writes only once drained
	always @(negedge clk) begin
		step_t s;
		logic nstart;
		nstart = start;
		if (arst_n && !(start && !took)) begin
			nstart = 0;
			if (apb_st == 1) begin
				penable <= 1;
				apb_st <= 2;
			end else if (apb_st == 2) begin
				psel <= 0;
				penable <= 0;
				pwrite <= 0;
				apb_st <= 0;
			end else if (pending_items.size() != 0) begin
				s = pending_items[0];
				if (s.kind == K_ITEM) begin
					if (s.steady || $urandom_range(99) >= 32) begin
						mode <= s.mode;
						src_mac <= s.mac;
						node_id <= s.node;
						nstart = 1;
						void'(pending_items.pop_front());
					end
				end else if (due_results.size() == 0 && !busy && !start) begin
					if (settle < SETTLE_CYCLES) begin
						settle <= settle + 1;
					end else begin
						settle <= 0;
						psel <= 1;
						pwrite <= 1;
						paddr <= s.addr;
						pwdata <= s.data;
						apb_st <= 1;
						void'(pending_items.pop_front());
					end
				end
			end
		end
		start <= nstart;
	end

	task automatic add_item(input logic [1:0] m, input logic [47:0] mac, input logic [7:0] node,
			input bit steady = 0);
		step_t s;
		s = '{kind: K_ITEM, mode: m, mac: mac, node: node, addr: '0, data: '0, steady: steady};
		pending_items.push_back(s);
	endtask

	task automatic add_cfg(input int idx, input logic [31:0] val);
		step_t s;
		s = '{kind: K_CFG, mode: MODE_TICK, mac: '0, node: '0, addr: 5'(idx * 4), data: val,
			steady: 0};
		pending_items.push_back(s);
	endtask

	task automatic add_cfg_all(input int di, input int dw, input int pi, input int pt,
			input int sl, input int pu);
		add_cfg(REG_DISC_INTERVAL, di);
		add_cfg(REG_DISC_WINDOW, dw);
		add_cfg(REG_POLL_INTERVAL, pi);
		add_cfg(REG_POLL_TIMEOUT, pt);
		add_cfg(REG_STALE_LIMIT, sl);
		add_cfg(REG_PUBLISH_INTERVAL, pu);
	endtask

	// mostly ticks, responses from a small pool of peers, a few unused modes
	task automatic add_random(input int n, input bit steady);
		int pick;
		logic [1:0] m;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			m = pick < 66 ? MODE_TICK : pick < 82 ? MODE_DISC : pick < 96 ? MODE_POLL
				: MODE_UNUSED;
			if (m == MODE_TICK)
				add_item(m, {$urandom, $urandom}, 8'($urandom), steady);
			else if ($urandom_range(19) == 0)
				add_item(m, {$urandom, $urandom}, 8'($urandom), steady);
			else
				add_item(m, mac_pool[$urandom_range(19)], 8'($urandom), steady);
		end
	endtask

	// time limit
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 2; i < 20; i++) mac_pool[i] = {$urandom, $urandom};

		// directed: defaults, extremes of the fields, known and unknown peers
		add_item(MODE_TICK, '0, '0, 1);
		add_item(MODE_UNUSED, '1, '1, 1);
		add_item(MODE_DISC, '0, 8'hff, 1);
		add_item(MODE_POLL, '1, 8'h00, 1);
		add_item(MODE_DISC, '1, 8'h5a, 1);
		add_item(MODE_POLL, '0, 8'h33, 1);
		add_item(MODE_TICK, '1, '1, 1);
		add_item(MODE_TICK, '0, '0, 1);
		add_cfg_all(6, 2, 3, 1, 4, 2);
		for (int i = 0; i < 12; i++) add_item(MODE_TICK, '0, '0, 1);
		add_item(MODE_POLL, mac_pool[2], 8'h01, 1);
		add_item(MODE_TICK, '0, '0, 1);

		// random phases over several register settings
		add_cfg_all(60, 5, 20, 2, 40, 6);
		add_cfg(REG_UNUSED, 32'h1234);
		add_random(180, 0);
		add_cfg_all(1, 1, 1, 1, 1, 1);
		add_random(120, 1);
		add_cfg_all(0, 0, 0, 0, 0, 0);
		add_random(80, 0);
		for (int p = 0; p < 3; p++) begin
			add_cfg_all($urandom_range(20, 90), $urandom_range(1, 10), $urandom_range(5, 30),
				$urandom_range(0, 4), $urandom_range(10, 80), $urandom_range(1, 12));
			add_random(110, 0);
		end
		add_cfg_all(65535, 65535, 65535, 65535, 65535, 65535);
		add_random(60, 0);
		add_cfg_all(40, 3, 12, 1, 25, 5);
		add_random(80, 0);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;

		wait (pending_items.size() == 0 && !start && apb_st == 0 && due_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_results.size() != 0) report_mismatch("results never came", due_results.size(), 0);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
